// ----- design/etx_pkg.sv -----
// ----------------------------------------------------------------------------
// etx_pkg
// Shared constants for the Ethernet transmit pad and FCS block.
// ----------------------------------------------------------------------------
package etx_pkg;

   // Byte and counter widths
   localparam int BYTE_W         = 8;
   localparam int COUNT_W        = 12;
   localparam int MAX_W          = 11;
   localparam int PAD_W          = 6;
   localparam int CRC_W          = 32;
   localparam int STAT_WIDTH_DEF = 32;

   // CRC-32, reflected form
   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
   localparam logic [CRC_W-1:0] CRC_SEED = 32'hFFFFFFFF;

   // Frame length limits in bytes, without FCS
   localparam logic [COUNT_W-1:0] MIN_FRAME  = 12'd60;
   localparam logic [COUNT_W-1:0] MIN_HEADER = 12'd14;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 12'd4095;
   localparam logic [MAX_W-1:0]   MAX_FRAME_RESET = 11'd1514;

   // FCS byte positions, least significant first
   localparam logic [1:0] FCS_BYTE0 = 2'd0;
   localparam logic [1:0] FCS_BYTE1 = 2'd1;
   localparam logic [1:0] FCS_BYTE2 = 2'd2;
   localparam logic [1:0] FCS_BYTE3 = 2'd3;

endpackage

// ----- design/etx_crc_step.sv -----
// ----------------------------------------------------------------------------
// etx_crc_step
// One-byte update of the reflected Ethernet CRC-32.
// ----------------------------------------------------------------------------
module etx_crc_step (
   input  logic [etx_pkg::CRC_W-1:0]  crc_cur,
   input  logic [etx_pkg::BYTE_W-1:0] data,
   output logic [etx_pkg::CRC_W-1:0]  crc_next
);
   import etx_pkg::*;

   // Fold in the byte, then shift out eight bits against the polynomial
   always_comb begin
      logic [CRC_W-1:0] c;
      c = crc_cur ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int i = 0; i < BYTE_W; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      crc_next = c;
   end

endmodule

// ----- design/ethernet_tx_pad_and_fcs.sv -----
// ----------------------------------------------------------------------------
// ethernet_tx_pad_and_fcs
// Passes frame bytes through, pads short frames to 60 bytes, appends the
// inverted CRC-32 as FCS and aborts frames of invalid length.
// ----------------------------------------------------------------------------
// An accepted byte is registered in the result slot and shown on the rsp side in the cycle after.
// Throughput: one byte per cycle through the frame body while rsp_tready is high.
// After the last byte of a good frame the req side is held while the pad bytes
// (0 to 46) and the four FCS bytes go out on the result stream.
// Reset: synchronous, active high; seeds the CRC, clears counters, tail state and the
// result slot, and loads max_frame_bytes with 1514.
module ethernet_tx_pad_and_fcs #(
   parameter int STAT_WIDTH = etx_pkg::STAT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [etx_pkg::MAX_W-1:0] csr_wr_data,   // max_frame_bytes
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [etx_pkg::BYTE_W-1:0] req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,                   // frame_end
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte, sent_total, dropped_total from bit 0 up, zero filled to bytes
   output logic [((etx_pkg::BYTE_W+2*STAT_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic        rsp_tlast,                   // out_last
   output logic        rsp_tuser                    // frame_abort
);
   import etx_pkg::*;

   localparam int RSP_DATA_W = ((BYTE_W + 2*STAT_WIDTH + 7) / 8) * 8;

   // State
   logic [MAX_W-1:0]      max_ff, max_in;
   logic [CRC_W-1:0]      crc_ff, crc_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [STAT_WIDTH-1:0] sent_ff, sent_in;
   logic [STAT_WIDTH-1:0] dropped_ff, dropped_in;
   logic                  tail_active_ff, tail_active_in;
   logic [PAD_W-1:0]      pad_left_ff, pad_left_in;
   logic [1:0]            fcs_idx_ff, fcs_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_abort_ff, rsp_abort_in;

   // Datapath
   logic                  out_free;
   logic                  req_fire;
   logic                  tail_fire;
   logic [COUNT_W-1:0]    len;
   logic                  in_range;
   logic                  too_short;
   logic [COUNT_W-1:0]    pad_diff;
   logic [PAD_W-1:0]      pad_need;
   logic [BYTE_W-1:0]     crc_data;
   logic [CRC_W-1:0]      crc_next;
   logic [CRC_W-1:0]      fcs;
   logic [BYTE_W-1:0]     fcs_byte;

   // Handshake: the result slot empties or is empty, and no tail is running
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !tail_active_ff && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign tail_fire  = tail_active_ff && out_free;

   // Length of the frame including this byte, saturating
   assign len       = (count_ff == COUNT_MAX) ? count_ff : count_ff + 12'd1;
   assign in_range  = len <= {1'b0, max_ff};
   assign too_short = len < MIN_HEADER;
   assign pad_diff  = MIN_FRAME - len;
   assign pad_need  = (len < MIN_FRAME) ? pad_diff[PAD_W-1:0] : '0;

   // Shared CRC byte unit: frame byte in the body, zero during padding
   assign crc_data = tail_active_ff ? '0 : req_tdata;

   etx_crc_step u_crc (
      .crc_cur  (crc_ff),
      .data     (crc_data),
      .crc_next (crc_next)
   );

   // Select the FCS byte, least significant first
   assign fcs = ~crc_ff;
   always_comb begin
      case (fcs_idx_ff)
         FCS_BYTE0: fcs_byte = fcs[7:0];
         FCS_BYTE1: fcs_byte = fcs[15:8];
         FCS_BYTE2: fcs_byte = fcs[23:16];
         FCS_BYTE3: fcs_byte = fcs[31:24];
         default:   fcs_byte = fcs[7:0];
      endcase
   end

   // Next state and next result
   always_comb begin
      max_in         = csr_wr_en ? csr_wr_data : max_ff;
      crc_in         = crc_ff;
      count_in       = count_ff;
      sent_in        = sent_ff;
      dropped_in     = dropped_ff;
      tail_active_in = tail_active_ff;
      pad_left_in    = pad_left_ff;
      fcs_idx_in     = fcs_idx_ff;
      rsp_valid_in   = out_free ? 1'b0 : rsp_valid_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_abort_in   = rsp_abort_ff;

      if (req_fire) begin
         count_in = len;
         if (!req_tlast) begin
            // body byte: pass it on, or swallow it past the maximum
            if (in_range) begin
               crc_in       = crc_next;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = req_tdata;
               rsp_last_in  = 1'b0;
               rsp_abort_in = 1'b0;
            end
         end else if (too_short || !in_range) begin
            // bad length: abort the frame
            dropped_in   = dropped_ff + STAT_WIDTH'(1);
            rsp_valid_in = 1'b1;
            rsp_byte_in  = in_range ? req_tdata : '0;
            rsp_last_in  = 1'b1;
            rsp_abort_in = 1'b1;
            crc_in       = CRC_SEED;
            count_in     = '0;
         end else begin
            // good frame: send last byte, then start pad and FCS
            crc_in         = crc_next;
            sent_in        = sent_ff + STAT_WIDTH'(1);
            rsp_valid_in   = 1'b1;
            rsp_byte_in    = req_tdata;
            rsp_last_in    = 1'b0;
            rsp_abort_in   = 1'b0;
            count_in       = '0;
            tail_active_in = 1'b1;
            pad_left_in    = pad_need;
            fcs_idx_in     = FCS_BYTE0;
         end
      end else if (tail_fire) begin
         rsp_valid_in = 1'b1;
         rsp_abort_in = 1'b0;
         if (pad_left_ff != '0) begin
            // pad byte enters the CRC
            crc_in      = crc_next;
            rsp_byte_in = '0;
            rsp_last_in = 1'b0;
            pad_left_in = pad_left_ff - PAD_W'(1);
         end else begin
            // FCS byte; the fourth closes the frame
            rsp_byte_in = fcs_byte;
            rsp_last_in = (fcs_idx_ff == FCS_BYTE3);
            fcs_idx_in  = fcs_idx_ff + 2'd1;
            if (fcs_idx_ff == FCS_BYTE3) begin
               tail_active_in = 1'b0;
               crc_in         = CRC_SEED;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff         <= MAX_FRAME_RESET;
         crc_ff         <= CRC_SEED;
         count_ff       <= '0;
         sent_ff        <= '0;
         dropped_ff     <= '0;
         tail_active_ff <= 1'b0;
         pad_left_ff    <= '0;
         fcs_idx_ff     <= FCS_BYTE0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_ff         <= max_in;
         crc_ff         <= crc_in;
         count_ff       <= count_in;
         sent_ff        <= sent_in;
         dropped_ff     <= dropped_in;
         tail_active_ff <= tail_active_in;
         pad_left_ff    <= pad_left_in;
         fcs_idx_ff     <= fcs_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_abort_ff <= rsp_abort_in;
   end

   // Outputs; counters only move when the result slot is refilled
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({dropped_ff, sent_ff, rsp_byte_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_abort_ff;

   // Checks
   a_tail_blocks_input: assert property (@(posedge clock) disable iff (reset)
      tail_active_ff |-> !req_tready)
      else $error("input accepted during pad/FCS tail");

   a_abort_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("abort flagged on a non-final byte");

   a_pad_only_in_tail: assert property (@(posedge clock) disable iff (reset)
      (pad_left_ff != '0) |-> tail_active_ff)
      else $error("pad count pending outside tail");

   a_crc_reseed: assert property (@(posedge clock) disable iff (reset)
      (tail_fire && pad_left_ff == '0 && fcs_idx_ff == FCS_BYTE3)
         |=> (crc_ff == CRC_SEED && count_ff == '0))
      else $error("CRC not reseeded after FCS");

   a_last_fcs_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && !rsp_tuser) |-> !tail_active_ff)
      else $error("final FCS byte shown while tail still running");

endmodule
